// ===== design/fur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fur_pkg - shared types and constants for the first-use register renamer
// Widths of the register fields, map depth, counter limit and the item and
// result structures passed between the renamer core and the top level.
// ----------------------------------------------------------------------------
package fur_pkg;

  // register count of the target and size of the renaming map
  localparam int NUM_REGS  = 16;
  localparam int MAP_DEPTH = 16;
  localparam int REG_W     = 4;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(16);
  localparam logic [CNT_W-1:0] LAST_INDEX  = CNT_W'(NUM_REGS - 1);

  // bank codes: which map store holds an entry
  localparam logic BANK_SRC = 1'b0;
  localparam logic BANK_DST = 1'b1;

  typedef struct packed {
    logic             start_of_sequence;
    logic             has_source_reg;
    logic [REG_W-1:0] source_reg;
    logic [REG_W-1:0] dest_reg;
  } fur_item_t;

  typedef struct packed {
    logic             has_source_out;
    logic [IDX_W-1:0] renamed_source;
    logic [IDX_W-1:0] renamed_dest;
  } fur_result_t;

  // one map store write, kept in the record to cover the read that missed it
  typedef struct packed {
    logic             en;
    logic [REG_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } fur_wr_t;

  // index handed to a newly seen register, clamped to the last dense index
  function automatic logic [IDX_W-1:0] give_index(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] c;
    begin
      c = (cnt > LAST_INDEX) ? LAST_INDEX : cnt;
      return c[IDX_W-1:0];
    end
  endfunction

  // counter advance, saturating at the limit
  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] cnt);
    begin
      return (cnt < COUNT_LIMIT) ? cnt + CNT_W'(1) : cnt;
    end
  endfunction

endpackage

// ===== design/fur_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fur_ram - generic RAM, one write port and two registered read ports
// Read data appears the cycle after a read enable and holds until the next.
// ----------------------------------------------------------------------------
module fur_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/fur_rename.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fur_rename - input stage, renaming map and single-pass rename logic
// Valid and bank bits live in flops; indices live in two small stores, one
// written by source insertions and one by destination insertions. Stores
// are read as the item is taken; the previous item's writes are forwarded.
// ----------------------------------------------------------------------------
module fur_rename (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fur_pkg::fur_item_t   in_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output fur_pkg::fur_result_t res
);
  import fur_pkg::*;

  logic                 s1_valid;
  fur_item_t            s1_item;
  logic                 accept;
  logic                 adv;

  logic [MAP_DEPTH-1:0] map_valid;
  logic [MAP_DEPTH-1:0] map_valid_next;
  logic [MAP_DEPTH-1:0] map_bank;
  logic [CNT_W-1:0]     next_index;

  fur_wr_t              rec_s;
  fur_wr_t              rec_d;
  fur_wr_t              wr_s;
  fur_wr_t              wr_d;

  logic [IDX_W-1:0]     qs_src;
  logic [IDX_W-1:0]     qs_dst;
  logic [IDX_W-1:0]     qd_src;
  logic [IDX_W-1:0]     qd_dst;

  logic [MAP_DEPTH-1:0] v_eff;
  logic [CNT_W-1:0]     cnt0;
  logic [CNT_W-1:0]     cnt1;
  logic [CNT_W-1:0]     cnt2;
  logic                 hit_s;
  logic                 hit_d;
  logic                 same_reg;
  logic [IDX_W-1:0]     idx_s;
  logic [IDX_W-1:0]     idx_d;

  // index already held for a register: latest write first, then the stores
  function automatic logic [IDX_W-1:0] stored_index(
    input logic [REG_W-1:0] a,
    input fur_wr_t          rs,
    input fur_wr_t          rd,
    input logic             bank,
    input logic [IDX_W-1:0] q_src_store,
    input logic [IDX_W-1:0] q_dst_store
  );
    begin
      if (rs.en && rs.addr == a) return rs.data;
      else if (rd.en && rd.addr == a) return rd.data;
      else if (bank == BANK_DST) return q_dst_store;
      else return q_src_store;
    end
  endfunction

  // handshake: the stage empties into the result side whenever it is free
  assign adv      = s1_valid && (!res_valid || res_ready);
  assign in_ready = !s1_valid || adv;
  assign accept   = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  // index stores, read at the item's two registers as it is taken
  fur_ram #(.WIDTH(IDX_W), .DEPTH(MAP_DEPTH)) u_store_src (
    .clk     (clk),
    .we      (wr_s.en),
    .waddr   (wr_s.addr),
    .wdata   (wr_s.data),
    .re      (accept),
    .raddr_a (in_item.source_reg),
    .raddr_b (in_item.dest_reg),
    .rdata_a (qs_src),
    .rdata_b (qs_dst)
  );

  fur_ram #(.WIDTH(IDX_W), .DEPTH(MAP_DEPTH)) u_store_dst (
    .clk     (clk),
    .we      (wr_d.en),
    .waddr   (wr_d.addr),
    .wdata   (wr_d.data),
    .re      (accept),
    .raddr_a (in_item.source_reg),
    .raddr_b (in_item.dest_reg),
    .rdata_a (qd_src),
    .rdata_b (qd_dst)
  );

  // rename: source first, then destination
  always_comb begin
    v_eff    = s1_item.start_of_sequence ? '0 : map_valid;
    cnt0     = s1_item.start_of_sequence ? '0 : next_index;
    same_reg = s1_item.has_source_reg && (s1_item.source_reg == s1_item.dest_reg);

    hit_s = v_eff[s1_item.source_reg];
    if (!s1_item.has_source_reg) begin
      idx_s = '0;
      cnt1  = cnt0;
    end else if (hit_s) begin
      idx_s = stored_index(s1_item.source_reg, rec_s, rec_d,
                           map_bank[s1_item.source_reg], qs_src, qd_src);
      cnt1  = cnt0;
    end else begin
      idx_s = give_index(cnt0);
      cnt1  = count_up(cnt0);
    end

    hit_d = v_eff[s1_item.dest_reg];
    if (same_reg) begin
      idx_d = idx_s;
      cnt2  = cnt1;
    end else if (hit_d) begin
      idx_d = stored_index(s1_item.dest_reg, rec_s, rec_d,
                           map_bank[s1_item.dest_reg], qs_dst, qd_dst);
      cnt2  = cnt1;
    end else begin
      idx_d = give_index(cnt1);
      cnt2  = count_up(cnt1);
    end

    wr_s.en   = adv && s1_item.has_source_reg && !hit_s;
    wr_s.addr = s1_item.source_reg;
    wr_s.data = idx_s;
    wr_d.en   = adv && !same_reg && !hit_d;
    wr_d.addr = s1_item.dest_reg;
    wr_d.data = idx_d;

    map_valid_next = v_eff;
    if (wr_s.en) map_valid_next[wr_s.addr] = 1'b1;
    if (wr_d.en) map_valid_next[wr_d.addr] = 1'b1;
  end

  // map state and the forwarding record
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid  <= '0;
      next_index <= '0;
      rec_s      <= '0;
      rec_d      <= '0;
    end else if (adv) begin
      map_valid  <= map_valid_next;
      next_index <= cnt2;
      rec_s      <= wr_s;
      rec_d      <= wr_d;
    end
  end

  // which store holds the latest index of each register
  always_ff @(posedge clk) begin
    if (wr_s.en) map_bank[wr_s.addr] <= BANK_SRC;
    if (wr_d.en) map_bank[wr_d.addr] <= BANK_DST;
  end

  // result handed to the output register
  assign res.has_source_out = s1_item.has_source_reg;
  assign res.renamed_source = idx_s;
  assign res.renamed_dest   = idx_d;

  // result register flag mirrors the stage hand-over
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      res_valid <= s1_valid;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    next_index <= COUNT_LIMIT)
    else $error("rename counter beyond its limit");

  a_dest_mapped: assert property (@(posedge clk) disable iff (rst)
    adv |=> map_valid[$past(s1_item.dest_reg)])
    else $error("destination register not mapped after rename");

  a_src_mapped: assert property (@(posedge clk) disable iff (rst)
    adv && s1_item.has_source_reg |=> map_valid[$past(s1_item.source_reg)])
    else $error("source register not mapped after rename");

  a_same_index: assert property (@(posedge clk) disable iff (rst)
    s1_valid && same_reg |-> idx_s == idx_d)
    else $error("same register renamed to two indices");

endmodule

// ===== design/first_use_register_renamer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_use_register_renamer_top - dense renaming of instruction registers
//
//   channel   direction  payload
//   s_axis    in         tdata: source_reg, dest_reg; tuser: start, has_source
//   m_axis    out        tdata: renamed_source, renamed_dest; tuser: has_source
//
// One instruction per cycle sustained while m_axis is not stalled; a result passes
// the input stage, then the output register, before it leaves.
// The map read and the rename decision sit in the single input stage.
// Reset clears the map valid bits and the counter at once; no sweep.
// A stalled output holds its result while one more transaction is taken.
// ----------------------------------------------------------------------------
module first_use_register_renamer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [3:0] source_reg, [7:4] dest_reg
  input  logic [1:0] s_axis_tuser,  // [0] start_of_sequence, [1] has_source_reg
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [3:0] renamed_source, [7:4] renamed_dest
  output logic [0:0] m_axis_tuser   // [0] has_source_out
);
  import fur_pkg::*;

  fur_item_t   in_item;
  fur_result_t res;
  fur_result_t out_q;
  logic        res_valid;

  // unpack the incoming transaction
  assign in_item.start_of_sequence = s_axis_tuser[0];
  assign in_item.has_source_reg    = s_axis_tuser[1];
  assign in_item.source_reg        = s_axis_tdata[3:0];
  assign in_item.dest_reg          = s_axis_tdata[7:4];

  fur_rename u_rename (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // output register payload
  always_ff @(posedge clk) begin
    if (!res_valid || m_axis_tready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid   = res_valid;
  assign m_axis_tdata    = {out_q.renamed_dest, out_q.renamed_source};
  assign m_axis_tuser[0] = out_q.has_source_out;

endmodule

// ===== dv/fur_rename_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fur_rename_checker - scoreboard for the first-use register renamer
// Watches both stream channels, keeps its own map of first appearances to
// work out the renamed operands of every accepted instruction, and compares
// each result leaving the block, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module fur_rename_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [3:0] source_reg, [7:4] dest_reg
  input  logic [1:0] s_axis_tuser,  // [0] start_of_sequence, [1] has_source_reg
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,  // [3:0] renamed_source, [7:4] renamed_dest
  input  logic [0:0] m_axis_tuser,  // [0] has_source_out
  output int         mismatches,
  output int         outstanding,
  output int         renames_checked
);

  import fur_pkg::*;

  // shadow of the renaming map
  logic             seen_valid [MAP_DEPTH];
  logic [IDX_W-1:0] seen_index [MAP_DEPTH];
  logic [CNT_W-1:0] next_dense;

  // renamed operands still owed by the block, oldest first
  fur_result_t expected_renames[$];

  int fail_count;
  int checked_count;

  function automatic void forget_registers();
    for (int i = 0; i < MAP_DEPTH; i++) begin
      seen_valid[i] = 1'b0;
      seen_index[i] = '0;
    end
    next_dense = '0;
  endfunction

  // dense index of one original register, handing out a new one on first use
  function automatic logic [IDX_W-1:0] dense_index_of(input logic [REG_W-1:0] orig);
    logic [IDX_W-1:0] given;
    if (seen_valid[orig]) begin
      return seen_index[orig];
    end
    // past the register count every newcomer shares the last index
    if (next_dense > CNT_W'(NUM_REGS - 1)) begin
      given = IDX_W'(NUM_REGS - 1);
    end else begin
      given = next_dense[IDX_W-1:0];
    end
    seen_valid[orig] = 1'b1;
    seen_index[orig] = given;
    if (next_dense < COUNT_LIMIT) begin
      next_dense = next_dense + CNT_W'(1);
    end
    return given;
  endfunction

  // source first, then destination, so a new register used twice gets one index
  function automatic fur_result_t rename_operands(input fur_item_t insn);
    fur_result_t r;
    if (insn.start_of_sequence) begin
      forget_registers();
    end
    r.has_source_out = insn.has_source_reg;
    r.renamed_source = '0;
    if (insn.has_source_reg) begin
      r.renamed_source = dense_index_of(insn.source_reg);
    end
    r.renamed_dest = dense_index_of(insn.dest_reg);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input fur_result_t want,
                                 input fur_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected has_src=%0b src=%0d dst=%0d, got has_src=%0b src=%0d dst=%0d",
               $realtime, what, want.has_source_out, want.renamed_source,
               want.renamed_dest, got.has_source_out, got.renamed_source,
               got.renamed_dest);
    end
  endtask

  // predict on every input transaction, compare on every output transaction
  always @(posedge clk) begin : watch
    fur_item_t   insn;
    fur_result_t got;
    fur_result_t want;
    if (rst) begin
      forget_registers();
      expected_renames.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        insn.start_of_sequence = s_axis_tuser[0];
        insn.has_source_reg    = s_axis_tuser[1];
        insn.source_reg        = s_axis_tdata[3:0];
        insn.dest_reg          = s_axis_tdata[7:4];
        expected_renames = {expected_renames, rename_operands(insn)};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.has_source_out = m_axis_tuser[0];
        got.renamed_source = m_axis_tdata[3:0];
        got.renamed_dest   = m_axis_tdata[7:4];
        if (expected_renames.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = expected_renames.pop_front();
          checked_count++;
          if (got.has_source_out != want.has_source_out ||
              got.renamed_source != want.renamed_source ||
              got.renamed_dest   != want.renamed_dest) begin
            report_mismatch("renamed operands differ", want, got);
          end
        end
      end
    end
    mismatches      <= fail_count;
    outstanding     <= expected_renames.size();
    renames_checked <= checked_count;
  end

endmodule

// ===== dv/tb_first_use_register_renamer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_use_register_renamer_top - stimulus and verdict for the renamer
// Sends a short directed set of instructions, then random sequences of
// instructions drawn from register pools of varying size, under phases of
// free flow, sparse input, stalled output and both, plus one long output
// hold-off that backs the block up. Checking is done by fur_rename_checker.
// ----------------------------------------------------------------------------
module tb_first_use_register_renamer_top;

  localparam int RANDOM_INSNS = 1680;
  localparam int HOLD_CYCLES  = 300;

  logic       clk;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;  // [3:0] source_reg, [7:4] dest_reg
  logic [1:0] s_axis_tuser  = '0;  // [0] start_of_sequence, [1] has_source_reg
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [3:0] renamed_source, [7:4] renamed_dest
  logic [0:0] m_axis_tuser;        // [0] has_source_out

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_request   = 1'b0;
  logic hold_off       = 1'b0;

  int mismatches;
  int outstanding;
  int renames_checked;
  int insns_sent     = 0;
  int sequences_sent = 0;
  int sources_sent   = 0;

  first_use_register_renamer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  fur_rename_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .renames_checked (renames_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("== FAIL ==");
    $finish;
  end

  // output side: random stalls, forced low during the hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one long output hold-off while input keeps coming, to back the block up
  initial begin : long_hold_off
    int held;
    @(posedge clk);
    while (!hold_request) @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one instruction, idling first at random, and wait for its transaction
  task automatic send_insn(input logic start, input logic has_src,
                           input logic [3:0] src, input logic [3:0] dst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dst, src};
    s_axis_tuser  <= {has_src, start};
    do @(posedge clk); while (!s_axis_tready);
    insns_sent++;
    sequences_sent += start;
    sources_sent   += has_src;
  endtask

  initial begin : stimulus
    int   sent;
    int   phase;
    int   seq_len;
    int   pool_top;
    int   drain;
    logic start;
    logic has_src;
    logic [3:0] src;
    logic [3:0] dst;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: immediate source, hit, same new register twice, extremes
    send_insn(1'b1, 1'b0, 4'hf, 4'h0);
    send_insn(1'b0, 1'b1, 4'h0, 4'h0);
    send_insn(1'b0, 1'b1, 4'h5, 4'h5);
    send_insn(1'b0, 1'b1, 4'hf, 4'h3);
    send_insn(1'b0, 1'b0, 4'h5, 4'hf);
    // fill every register so the counter reaches its limit
    send_insn(1'b0, 1'b1, 4'h1, 4'h2);
    send_insn(1'b0, 1'b1, 4'h4, 4'h6);
    send_insn(1'b0, 1'b1, 4'h7, 4'h8);
    send_insn(1'b0, 1'b1, 4'h9, 4'ha);
    send_insn(1'b0, 1'b1, 4'hb, 4'hc);
    send_insn(1'b0, 1'b1, 4'hd, 4'he);
    send_insn(1'b0, 1'b1, 4'he, 4'h0);
    send_insn(1'b0, 1'b0, 4'h0, 4'hd);
    // clears in mid sequence and back to back
    send_insn(1'b1, 1'b1, 4'h9, 4'h9);
    send_insn(1'b0, 1'b1, 4'h0, 4'h9);
    send_insn(1'b1, 1'b0, 4'h9, 4'hf);
    send_insn(1'b1, 1'b1, 4'hf, 4'h0);
    send_insn(1'b0, 1'b0, 4'ha, 4'hf);

    // random sequences, phase by phase
    sent = 0;
    while (sent < RANDOM_INSNS) begin
      phase = sent * 4 / RANDOM_INSNS;
      case (phase)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
          if (sent >= 40) hold_request <= 1'b1;
        end
        1: begin
          send_idle_pct  <= 88;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 88;
        end
        default: begin
          send_idle_pct  <= 28;
          recv_stall_pct <= 28;
        end
      endcase
      // mostly short sequences, some long enough to use up every register
      seq_len  = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      pool_top = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : 15;
      for (int k = 0; k < seq_len; k++) begin
        // an occasional stray clear breaks a sequence early
        start   = (k == 0) || ($urandom_range(24) == 0);
        has_src = ($urandom_range(3) != 0);
        src     = has_src ? 4'($urandom_range(pool_top)) : 4'($urandom_range(15));
        dst     = 4'($urandom_range(pool_top));
        send_insn(start, has_src, src, dst);
        sent++;
      end
    end

    // drain
    s_axis_tvalid  <= 1'b0;
    recv_stall_pct <= 0;
    drain = 0;
    while (outstanding != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (outstanding != 0) begin
      $display("%0d expected results never arrived", outstanding);
    end

    $display("renamer run: %0d instructions in %0d sequences, %0d with a source register",
             insns_sent, sequences_sent, sources_sent);
    $display("%0d results checked across free flow, sparse input, stalled output, both idling",
             renames_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fur_pkg.sv
design/fur_ram.sv
design/fur_rename.sv
design/first_use_register_renamer_top.sv
dv/fur_rename_checker.sv
dv/tb_first_use_register_renamer_top.sv
